FILE: hdl/bvp_pkg.sv
package bvp_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int MV_W    = 16;
    localparam int PCT_W   = 7;
    localparam int SCALE_W = 24;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = MV_W + PCT_W;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
    localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;
    localparam logic [MV_W-1:0]    MV_MAX      = 16'hFFFF;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SHORT = 2'd2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_LD_RD,
        ST_LD_CHK,
        ST_CV_MUL,
        ST_CV_SCL,
        ST_LK_START,
        ST_LK_CHK,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LD_RD,
        OP_LD_CHK,
        OP_MUL,
        OP_SCALE,
        OP_LK_START,
        OP_LK_CHK,
        OP_DIV_STEP,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        logic is_convert;
        logic drop;
        logic k_zero;
        logic ld_stop;
        logic count_zero;
        logic lk_match;
        logic lk_last;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hdl/bvp_ram.sv
module bvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/bvp_ctrl.sv
module bvp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bvp_pkg::dp_status_t status,
    output bvp_pkg::dp_op_t     op
);
    import bvp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISP;
            end
            ST_DISP: begin
                if (status.is_convert)  state_next = ST_CV_MUL;
                else if (status.drop)   state_next = ST_OUT;
                else                    state_next = ST_LD_RD;
            end
            ST_LD_RD: begin
                state_next = status.k_zero ? ST_OUT : ST_LD_CHK;
            end
            ST_LD_CHK: begin
                state_next = status.ld_stop ? ST_OUT : ST_LD_RD;
            end
            ST_CV_MUL:   state_next = ST_CV_SCL;
            ST_CV_SCL:   state_next = ST_LK_START;
            ST_LK_START: begin
                state_next = status.count_zero ? ST_OUT : ST_LK_CHK;
            end
            ST_LK_CHK: begin
                priority if (status.lk_match) state_next = ST_DIV;
                else if (status.lk_last)      state_next = ST_OUT;
            end
            ST_DIV: begin
                if (status.div_last) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op       = OP_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) op = OP_CAPTURE;
            end
            ST_DISP:     op = OP_NONE;
            ST_LD_RD:    op = OP_LD_RD;
            ST_LD_CHK:   op = OP_LD_CHK;
            ST_CV_MUL:   op = OP_MUL;
            ST_CV_SCL:   op = OP_SCALE;
            ST_LK_START: op = OP_LK_START;
            ST_LK_CHK:   op = OP_LK_CHK;
            ST_DIV:      op = OP_DIV_STEP;
            ST_OUT: begin
                if (status.out_free) op = OP_PUSH;
            end
            default:     op = OP_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_tvalid) |=> (state_reg == ST_DISP))
        else $error("accepted beat did not dispatch");
    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |=> (state_reg == ST_DIV || state_reg == ST_OUT))
        else $error("divider left to wrong state");
    a_out_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && status.out_free) |=> (state_reg == ST_IDLE))
        else $error("result push did not return to idle");
`endif

endmodule

FILE: hdl/bvp_datapath.sv
module bvp_datapath #(
    parameter int TABLE_DEPTH = bvp_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = bvp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bvp_pkg::dp_op_t             op,
    output bvp_pkg::dp_status_t         status,
    input  logic                        in_cmd,
    input  logic [bvp_pkg::MV_W-1:0]    in_mv,
    input  logic [bvp_pkg::PCT_W-1:0]   in_pct,
    input  logic [SAMPLE_BITS-1:0]      in_raw,
    input  logic                        cfg_valid,
    input  logic [bvp_pkg::SCALE_W-1:0] cfg_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bvp_pkg::PCT_W-1:0]   m_pct,
    output logic [bvp_pkg::MV_W-1:0]    m_mv,
    output logic [bvp_pkg::STAT_W-1:0]  m_stat
);
    import bvp_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W = SAMPLE_BITS + SCALE_W;
    localparam int NUM_W  = MV_W + PCT_W;
    localparam int IT_W   = $clog2(NUM_W);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic                 cmd_reg;
    logic                 drop_reg;
    logic [MV_W-1:0]      new_mv_reg;
    logic [PCT_W-1:0]     new_pct_reg;
    logic [SAMPLE_BITS-1:0] raw_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        k_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [MV_W-1:0]      mv_reg;
    logic [MV_W-1:0]      hi_mv_reg;
    logic [PCT_W-1:0]     hi_pct_reg;
    logic [MV_W-1:0]      top_mv_reg;
    logic                 found_reg;
    logic                 neg_reg;
    logic [PCT_W-1:0]     lp_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [MV_W-1:0]      den_reg;
    logic [MV_W-1:0]      rem_reg;
    logic [IT_W-1:0]      it_reg;
    logic                 m_valid_reg;
    logic [PCT_W-1:0]     m_pct_reg;
    logic [MV_W-1:0]      m_mv_reg;
    logic [STAT_W-1:0]    m_stat_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [MV_W-1:0]      rd_mv;
    logic [PCT_W-1:0]     rd_pct;

    logic [PROD_W+2:0]    prod5;
    logic [PROD_W-15:0]   mv_full;
    logic                 bracket;
    logic [PCT_W-1:0]     dpct;
    logic [MV_W:0]        rem_s;
    logic                 rem_ge;
    logic [PCT_W-1:0]     pct_res;
    logic [NUM_W-1:0]     head;
    logic                 out_free;

    bvp_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_mv  = ram_rdata[ENTRY_W-1:PCT_W];
    assign rd_pct = ram_rdata[PCT_W-1:0];

    // x5 then drop 17 fraction bits: raw * scale * 2.5 / 65536
    assign prod5   = {prod_reg, 2'b00} + {2'b00, prod_reg};
    assign mv_full = prod5[PROD_W+2:17];

    assign bracket = (mv_reg >= rd_mv) && (mv_reg < hi_mv_reg);
    assign dpct    = (hi_pct_reg >= rd_pct) ? (hi_pct_reg - rd_pct) : (rd_pct - hi_pct_reg);

    assign rem_s  = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge = rem_s >= {1'b0, den_reg};

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = k_reg[AW-1:0];
        ram_wdata = {new_mv_reg, new_pct_reg};
        ram_raddr = AW'(k_reg - 1'b1);
        unique case (op)
            OP_LD_RD: begin
                ram_we = (k_reg == '0);
            end
            OP_LD_CHK: begin
                ram_we = 1'b1;
                if (!(rd_mv >= new_mv_reg)) ram_wdata = ram_rdata;
            end
            OP_LK_START: ram_raddr = '0;
            OP_LK_CHK:   ram_raddr = AW'(k_reg + 1'b1);
            default: ;
        endcase
    end

    // final percentage from the lookup result
    always_comb begin
        head = NUM_W'(PCT_MAX - lp_reg);
        if (!found_reg) begin
            pct_res = (count_reg != '0 && mv_reg >= top_mv_reg) ? PCT_MAX : '0;
        end else if (neg_reg) begin
            pct_res = (num_reg >= NUM_W'(lp_reg)) ? '0 : (lp_reg - PCT_W'(num_reg));
        end else begin
            pct_res = (num_reg >= head) ? PCT_MAX : (lp_reg + PCT_W'(num_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg   <= SCALE_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) scale_reg <= cfg_data;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (ram_we && ram_wdata == {new_mv_reg, new_pct_reg}
                && (op == OP_LD_RD || rd_mv >= new_mv_reg)) begin
                count_reg <= count_reg + 1'b1;
            end
            if (op == OP_PUSH) m_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (op)
            OP_CAPTURE: begin
                cmd_reg     <= in_cmd;
                new_mv_reg  <= in_mv;
                new_pct_reg <= (in_pct > PCT_MAX) ? PCT_MAX : in_pct;
                raw_reg     <= in_raw;
                drop_reg    <= (count_reg == DEPTH_C);
                k_reg       <= count_reg;
            end
            OP_LD_CHK: begin
                k_reg <= k_reg - 1'b1;
            end
            OP_MUL: begin
                prod_reg <= PROD_W'(raw_reg) * PROD_W'(scale_reg);
            end
            OP_SCALE: begin
                mv_reg <= (|mv_full[PROD_W-15:MV_W]) ? MV_MAX : mv_full[MV_W-1:0];
            end
            OP_LK_START: begin
                k_reg     <= '0;
                found_reg <= 1'b0;
            end
            OP_LK_CHK: begin
                hi_mv_reg  <= rd_mv;
                hi_pct_reg <= rd_pct;
                k_reg      <= k_reg + 1'b1;
                if (k_reg == '0) top_mv_reg <= rd_mv;
                if (k_reg != '0 && bracket) begin
                    found_reg <= 1'b1;
                    neg_reg   <= hi_pct_reg < rd_pct;
                    lp_reg    <= rd_pct;
                    num_reg   <= NUM_W'(mv_reg - rd_mv) * NUM_W'(dpct);
                    den_reg   <= hi_mv_reg - rd_mv;
                    rem_reg   <= '0;
                    it_reg    <= '0;
                end
            end
            OP_DIV_STEP: begin
                // restoring divide, one quotient bit a cycle
                it_reg  <= it_reg + 1'b1;
                num_reg <= {num_reg[NUM_W-2:0], rem_ge};
                rem_reg <= rem_ge ? MV_W'(rem_s - {1'b0, den_reg}) : rem_s[MV_W-1:0];
            end
            OP_PUSH: begin
                if (cmd_reg == CMD_CONVERT) begin
                    m_pct_reg  <= pct_res;
                    m_mv_reg   <= mv_reg;
                    m_stat_reg <= (count_reg < CW'(2)) ? STAT_SHORT : STAT_OK;
                end else begin
                    m_pct_reg  <= '0;
                    m_mv_reg   <= '0;
                    m_stat_reg <= drop_reg ? STAT_FULL : STAT_OK;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        status.is_convert = (cmd_reg == CMD_CONVERT);
        status.drop       = drop_reg;
        status.k_zero     = (k_reg == '0);
        status.ld_stop    = (rd_mv >= new_mv_reg);
        status.count_zero = (count_reg == '0);
        status.lk_match   = (k_reg != '0) && bracket;
        status.lk_last    = (CW'(k_reg + 1'b1) == count_reg);
        status.div_last   = (it_reg == IT_W'(NUM_W - 1));
        status.out_free   = out_free;
    end

    assign m_valid = m_valid_reg;
    assign m_pct   = m_pct_reg;
    assign m_mv    = m_mv_reg;
    assign m_stat  = m_stat_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("table count beyond depth");
    a_push_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_PUSH) |=> m_valid_reg)
        else $error("pushed result not presented");
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_pct_reg <= PCT_MAX))
        else $error("percentage out of range");
`endif

endmodule

FILE: hdl/battery_voltage_to_percent.sv
// Battery voltage to charge percentage by piecewise linear lookup.
// Input channel s_*: one beat per item. tuser carries cmd (0 load a breakpoint,
// 1 convert a sample); tdata carries entry_millivolt, entry_percent, raw_sample.
// Load beats insert a (millivolt, percent) breakpoint into a table kept sorted
// by descending millivolt; a load into a full table is dropped with status 1.
// Convert beats scale the ADC count to millivolts, walk the table for the
// bracketing pair and interpolate with a serial divider.
// Result channel m_*: exactly one beat per input beat, held in an output
// register until taken; a stalled receiver only holds the block at its end.
// Config channel cfg_*: writes adc_scale_q16, always ready; write while idle.
// A load shifts each displaced table entry through the table RAM port; a
// convert walks the table, then runs the one-bit-per-cycle divider when a
// bracket is found. One item at a time.
// Reset (aresetn low, synchronous) empties the table and restores the scale
// to 1.0; no clearing pass is needed.
module battery_voltage_to_percent #(
    parameter int TABLE_DEPTH = bvp_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = bvp_pkg::SAMPLE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // [15:0] entry_millivolt, [22:16] entry_percent, then raw_sample, zero pad
    input  logic [((bvp_pkg::MV_W+bvp_pkg::PCT_W+SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // [0] cmd
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // [6:0] charge_percent, [22:7] battery_millivolt, [24:23] status, zero pad
    output logic [31:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [bvp_pkg::SCALE_W-1:0] cfg_data
);
    import bvp_pkg::*;

    localparam int RAW_LSB = MV_W + PCT_W;
    localparam int OUT_W   = PCT_W + MV_W + STAT_W;

    dp_op_t     op;
    dp_status_t status;
    logic [PCT_W-1:0]  m_pct;
    logic [MV_W-1:0]   m_mv;
    logic [STAT_W-1:0] m_stat;

    // configuration never stalls
    assign cfg_ready = 1'b1;

    bvp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    bvp_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .status    (status),
        .in_cmd    (s_tuser),
        .in_mv     (s_tdata[MV_W-1:0]),
        .in_pct    (s_tdata[MV_W+PCT_W-1:MV_W]),
        .in_raw    (s_tdata[RAW_LSB+SAMPLE_BITS-1:RAW_LSB]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_pct     (m_pct),
        .m_mv      (m_mv),
        .m_stat    (m_stat)
    );

    // pack the result beat, lowest field first
    assign m_tdata = {{(32-OUT_W){1'b0}}, m_stat, m_mv, m_pct};

endmodule
